// File: rtl/rri_pkg.sv
// ----------------------------------------------------------------------------
// rri_pkg
// shared constants for the ray / rectangle intersection core
// ----------------------------------------------------------------------------
package rri_pkg;

	// ray and result field widths (Q16.16 coordinates)
	localparam int FIELD_W    = 32;
	localparam int DIST_W     = 32;
	localparam int FRAC_BITS  = 16;

	// matrix rows: four signed Q4.12 entries per row
	localparam int COEF_W     = 16;
	localparam int MAT_FRAC   = 12;
	localparam int ROW_W      = 64;
	localparam int BOUND_W    = 31;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_X = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_Z = CFG_IDX_W'(4);

endpackage

// File: rtl/rri_if.sv
// ----------------------------------------------------------------------------
// rri interfaces
// ray input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface rri_ray_if;
	import rri_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] origin_x;
	logic signed [FIELD_W-1:0] origin_y;
	logic signed [FIELD_W-1:0] origin_z;
	logic signed [FIELD_W-1:0] dir_x;
	logic signed [FIELD_W-1:0] dir_y;
	logic signed [FIELD_W-1:0] dir_z;
	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rri_res_if;
	import rri_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DIST_W-1:0] distance;
	modport source(output valid, hit, distance, input ready);
	modport sink(input valid, hit, distance, output ready);
endinterface

interface rri_cfg_if;
	import rri_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/ray_rectangle_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_core
// pipelined ray test against a bounded rectangle in the object-space xz plane
// ----------------------------------------------------------------------------
// One ray enters per cycle and one result leaves per cycle. Each ray goes
// through COORD_WIDTH + 23 register stages: three for the matrix transform,
// one per quotient bit (COORD_WIDTH + 16 of them) in the restoring divider
// that forms t = -oy / dy, and four for saturation, hit point and bound test.
// The divider chain sets the latency; throughput is one ray per clock. All
// stages advance together whenever the output register is empty or its
// transfer completes, so a stall at the output holds every ray in place.
// A ray parallel to the plane gives hit 0 and distance 0. Configuration
// writes are taken in any cycle and must only happen while no ray is in flight.
module ray_rectangle_intersect_core #(
	parameter int COORD_WIDTH = 32
) (
	input logic     clk,
	input logic     arst_n,
	rri_ray_if.sink   ray,
	rri_res_if.source res,
	rri_cfg_if.sink   cfg
);
	import rri_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int PW   = COEF_W + FIELD_W;         // coefficient times coordinate
	localparam int SUMW = PW + 3;                   // three products plus translation
	localparam int NW   = W + FRAC_BITS;            // dividend and quotient bits
	localparam int HW   = 2 * W - FRAC_BITS + 2;    // hit point sum
	localparam int CMPW = (HW > BOUND_W) ? HW : BOUND_W;

	localparam logic signed [W-1:0] TMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] TMIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [63:0]  SMAX64 = 64'(TMAX);
	localparam logic signed [63:0]  SMIN64 = 64'(TMIN);

	// saturate a transformed coordinate to the coordinate width
	function automatic logic signed [W-1:0] sat_coord(input logic signed [63:0] x);
		logic signed [W-1:0] r;
		if (x > SMAX64) begin
			r = TMAX;
		end else if (x < SMIN64) begin
			r = TMIN;
		end else begin
			r = x[W-1:0];
		end
		return r;
	endfunction

	// ---------------- configuration registers ----------------
	logic [ROW_W-1:0]   row_q [3];
	logic [BOUND_W-1:0] bx_q;
	logic [BOUND_W-1:0] bz_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= '0;
			row_q[1] <= '0;
			row_q[2] <= '0;
			bx_q     <= '0;
			bz_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROW_X:   row_q[0] <= cfg.data;
				REG_ROW_Y:   row_q[1] <= cfg.data;
				REG_ROW_Z:   row_q[2] <= cfg.data;
				REG_BOUND_X: bx_q     <= cfg.data[BOUND_W-1:0];
				REG_BOUND_Z: bz_q     <= cfg.data[BOUND_W-1:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// ---------------- global pipeline enable ----------------
	logic adv;
	logic v_s7;
	assign adv       = !v_s7 || res.ready;
	assign ray.ready = adv;

	// ---------------- stage 1: matrix products ----------------
	logic signed [FIELD_W-1:0] org [3];
	logic signed [FIELD_W-1:0] dir [3];
	logic signed [PW-1:0]      po   [3][3];
	logic signed [PW-1:0]      pd   [3][3];
	logic signed [PW-1:0]      po_s1 [3][3];
	logic signed [PW-1:0]      pd_s1 [3][3];
	logic                      v_s1;

	always_comb begin
		org[0] = ray.origin_x;
		org[1] = ray.origin_y;
		org[2] = ray.origin_z;
		dir[0] = ray.dir_x;
		dir[1] = ray.dir_y;
		dir[2] = ray.dir_z;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				po[r][c] = $signed(row_q[r][c*COEF_W +: COEF_W]) * org[c];
				pd[r][c] = $signed(row_q[r][c*COEF_W +: COEF_W]) * dir[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			po_s1 <= po;
			pd_s1 <= pd;
		end
	end

	// ---------------- stage 2: sums, floor shift, saturate ----------------
	logic signed [SUMW-1:0] so [3];
	logic signed [SUMW-1:0] sd [3];
	logic signed [W-1:0]    o_s2 [3];
	logic signed [W-1:0]    d_s2 [3];
	logic                   v_s2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			// translation is Q4.12, lifted to the product scale
			so[r] = SUMW'(po_s1[r][0]) + SUMW'(po_s1[r][1]) + SUMW'(po_s1[r][2])
				+ (SUMW'($signed(row_q[r][ROW_W-1 -: COEF_W])) <<< FRAC_BITS);
			sd[r] = SUMW'(pd_s1[r][0]) + SUMW'(pd_s1[r][1]) + SUMW'(pd_s1[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				// dropping the low bits is a shift toward minus infinity
				o_s2[r] <= sat_coord(64'($signed(so[r][SUMW-1:MAT_FRAC])));
				d_s2[r] <= sat_coord(64'($signed(sd[r][SUMW-1:MAT_FRAC])));
			end
		end
	end

	// ---------------- stage 3 and divider chain ----------------
	typedef struct packed {
		logic [W-1:0]        rem;
		logic [NW-1:0]       nq;    // dividend bits shift out, quotient bits in
		logic [W-1:0]        d;
		logic                neg;
		logic                dyz;
		logic signed [W-1:0] ox;
		logic signed [W-1:0] oz;
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dz;
	} div_t;

	div_t div_s [NW+1];
	logic v_div [NW+1];

	logic [W-1:0] oy_mag;
	logic [W-1:0] dy_mag;
	assign oy_mag = o_s2[1][W-1] ? (~o_s2[1] + 1'b1) : o_s2[1];
	assign dy_mag = d_s2[1][W-1] ? (~d_s2[1] + 1'b1) : d_s2[1];

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].rem <= '0;
			div_s[0].nq  <= {oy_mag, {FRAC_BITS{1'b0}}};
			div_s[0].d   <= dy_mag;
			// sign of -oy / dy
			div_s[0].neg <= (!o_s2[1][W-1] && (|o_s2[1])) ^ d_s2[1][W-1];
			div_s[0].dyz <= (d_s2[1] == '0);
			div_s[0].ox  <= o_s2[0];
			div_s[0].oz  <= o_s2[2];
			div_s[0].dx  <= d_s2[0];
			div_s[0].dz  <= d_s2[2];
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [W:0]   r2;
		logic         ge;
		logic [W:0]   diff;
		div_t         nxt;
		assign r2   = {div_s[k].rem, div_s[k].nq[NW-1]};
		assign diff = r2 - {1'b0, div_s[k].d};
		assign ge   = (r2 >= {1'b0, div_s[k].d});

		// one restoring step; the side fields ride along unchanged
		always_comb begin
			nxt     = div_s[k];
			nxt.rem = ge ? diff[W-1:0] : r2[W-1:0];
			nxt.nq  = {div_s[k].nq[NW-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k+1] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div[k+1] <= 1'b0;
			end else if (adv) begin
				v_div[k+1] <= v_div[k];
			end
		end
	end

	// ---------------- stage 4: sign and saturate t ----------------
	logic [NW-W:0]       q_hi;
	logic                ovf_pos;
	logic                ovf_neg;
	logic signed [W-1:0] t_s4;
	logic signed [W-1:0] ox_s4, oz_s4, dx_s4, dz_s4;
	logic                dyz_s4;
	logic                v_s4;

	assign q_hi    = div_s[NW].nq[NW-1:W-1];
	assign ovf_pos = |q_hi;
	assign ovf_neg = (q_hi > (NW-W+1)'(1))
		|| ((q_hi == (NW-W+1)'(1)) && (|div_s[NW].nq[W-2:0]));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_s[NW].dyz) begin
				t_s4 <= '0;
			end else if (!div_s[NW].neg && ovf_pos) begin
				t_s4 <= TMAX;
			end else if (div_s[NW].neg && ovf_neg) begin
				t_s4 <= TMIN;
			end else if (div_s[NW].neg) begin
				t_s4 <= -$signed(div_s[NW].nq[W-1:0]);
			end else begin
				t_s4 <= $signed(div_s[NW].nq[W-1:0]);
			end
			ox_s4  <= div_s[NW].ox;
			oz_s4  <= div_s[NW].oz;
			dx_s4  <= div_s[NW].dx;
			dz_s4  <= div_s[NW].dz;
			dyz_s4 <= div_s[NW].dyz;
		end
	end

	// ---------------- stage 5: direction times t ----------------
	logic signed [2*W-1:0] px_s5, pz_s5;
	logic signed [W-1:0]   t_s5, ox_s5, oz_s5;
	logic                  dyz_s5;
	logic                  v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5  <= dx_s4 * t_s4;
			pz_s5  <= dz_s4 * t_s4;
			t_s5   <= t_s4;
			ox_s5  <= ox_s4;
			oz_s5  <= oz_s4;
			dyz_s5 <= dyz_s4;
		end
	end

	// ---------------- stage 6: hit point ----------------
	logic signed [HW-1:0] hx_s6, hz_s6;
	logic signed [W-1:0]  t_s6;
	logic                 dyz_s6;
	logic                 v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s6  <= HW'(ox_s5) + HW'($signed(px_s5[2*W-1:FRAC_BITS]));
			hz_s6  <= HW'(oz_s5) + HW'($signed(pz_s5[2*W-1:FRAC_BITS]));
			t_s6   <= t_s5;
			dyz_s6 <= dyz_s5;
		end
	end

	// ---------------- stage 7: bound test, output register ----------------
	logic [HW-1:0] ax, az;
	assign ax = hx_s6[HW-1] ? (~hx_s6 + 1'b1) : hx_s6;
	assign az = hz_s6[HW-1] ? (~hz_s6 + 1'b1) : hz_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			res.hit <= !dyz_s6 && (CMPW'(ax) < CMPW'(bx_q)) && (CMPW'(az) < CMPW'(bz_q));
			res.distance <= DIST_W'(t_s6);
		end
	end
	assign res.valid = v_s7;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_div[0] <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
		end else if (adv) begin
			v_s1     <= ray.valid;
			v_s2     <= v_s1;
			v_div[0] <= v_s2;
			v_s4     <= v_div[NW];
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
		end
	end

	// ---------------- assertions ----------------
	// divider leaves a remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		v_div[NW] && !div_s[NW].dyz |-> div_s[NW].rem < div_s[NW].d)
		else $error("divider remainder not below divisor");

	// a stall freezes the pipeline contents
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (v_s4 == $past(v_s4)) && (v_s6 == $past(v_s6)))
		else $error("pipeline moved during a stall");

	// a parallel ray reaches the output as a miss at zero distance
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && dyz_s6 && adv |=> res.valid && !res.hit && (res.distance == '0))
		else $error("parallel ray result wrong");

endmodule
